>>> src/mpq_pkg.sv
// Package for the min priority queue: word types, request and status codes, sizes.
`default_nettype none
package mpq_pkg;

    localparam int MPQ_DEPTH = 128;
    localparam int MPQ_VAL_W = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_PEEK   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                  req_type;
        logic signed [MPQ_VAL_W-1:0] item_value;
    } t_mpq_in;

    typedef struct packed {
        logic [1:0]                  status;
        logic signed [MPQ_VAL_W-1:0] min_value;
    } t_mpq_out;

    // Broadcast control to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del;
    } t_mpq_ctl;

endpackage
`default_nettype wire

>>> src/mpq_cell.sv
// One cell of the sorted chain: holds a value, shifts right on insert, left on delete.
`default_nettype none
module mpq_cell (
    input  logic                                 i_clk,
    input  mpq_pkg::t_mpq_ctl                    i_ctl,
    input  logic signed [mpq_pkg::MPQ_VAL_W-1:0] i_item,
    input  logic                                 i_valid,
    input  logic                                 i_left_gt,
    input  logic signed [mpq_pkg::MPQ_VAL_W-1:0] i_left_value,
    input  logic signed [mpq_pkg::MPQ_VAL_W-1:0] i_right_value,
    output logic                                 o_gt,
    output logic signed [mpq_pkg::MPQ_VAL_W-1:0] o_value
);
    import mpq_pkg::*;

    logic signed [MPQ_VAL_W-1:0] r_value;
    logic signed [MPQ_VAL_W-1:0] n_value;

    // Empty cells act as +infinity so the new item lands after all live ones.
    assign o_gt    = !i_valid || (r_value > i_item);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.ins) begin
            if (o_gt) begin
                n_value = i_left_gt ? i_left_value : i_item;
            end
        end else if (i_ctl.del) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
`default_nettype wire

>>> src/min_priority_queue.sv
// Top level of the min priority queue: request decode, entry count, cell chain, result register.
`default_nettype none
// Minimum-first priority queue of signed 32-bit values, built as a chain of
// QUEUE_DEPTH cells kept sorted ascending, with the smallest value in cell 0.
// Equal values stay in arrival order, so the earliest of several smallest
// values is served first. One request word is taken per cycle unless a
// result waits untaken: the new value is compared against every cell at once
// and the chain shifts right behind the insertion point (insert) or shifts
// left one place (delete). A delete or peek result is registered, appearing
// in the cycle after the request is accepted; the next request is taken in
// that cycle as long as the result register is free or being drained. Insert
// gives a result only when the queue is full (status full, value dropped).
// Delete or peek on an empty queue gives status empty with value zero.
// Request kind three is ignored. No clearing pass: after reset the queue is
// empty at once, since cell contents are qualified by the entry count.
module min_priority_queue #(
    parameter int QUEUE_DEPTH = mpq_pkg::MPQ_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mpq_pkg::t_mpq_in  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output mpq_pkg::t_mpq_out o_out_word
);
    import mpq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic             n_out_valid;
    t_mpq_out         r_out;
    t_mpq_out         n_out;

    t_mpq_ctl                    w_ctl;
    logic                        w_accept;
    logic                        w_empty;
    logic                        w_full;
    logic [QUEUE_DEPTH-1:0]      w_valid;
    logic [QUEUE_DEPTH-1:0]      w_gt;
    logic signed [MPQ_VAL_W-1:0] w_value [QUEUE_DEPTH];

    // Result register frees itself in the cycle it is taken.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_FULL);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Request decode.
    always_comb begin
        w_ctl       = '0;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        if (w_accept) begin
            case (i_in_word.req_type)
                REQ_INSERT: begin
                    if (w_full) begin
                        n_out_valid     = 1'b1;
                        n_out.status    = ST_FULL;
                        n_out.min_value = '0;
                    end else begin
                        w_ctl.ins = 1'b1;
                        n_count   = r_count + 1'b1;
                    end
                end
                REQ_DELETE: begin
                    n_out_valid = 1'b1;
                    if (w_empty) begin
                        n_out.status    = ST_EMPTY;
                        n_out.min_value = '0;
                    end else begin
                        n_out.status    = ST_OK;
                        n_out.min_value = w_value[0];
                        w_ctl.del       = 1'b1;
                        n_count         = r_count - 1'b1;
                    end
                end
                REQ_PEEK: begin
                    n_out_valid = 1'b1;
                    if (w_empty) begin
                        n_out.status    = ST_EMPTY;
                        n_out.min_value = '0;
                    end else begin
                        n_out.status    = ST_OK;
                        n_out.min_value = w_value[0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Cell chain; left of cell 0 never shifts in, right of the last cell is don't-care.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                        w_left_gt;
        logic signed [MPQ_VAL_W-1:0] w_left_value;
        logic signed [MPQ_VAL_W-1:0] w_right_value;

        assign w_valid[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign w_left_gt    = 1'b0;
            assign w_left_value = '0;
        end else begin : g_body
            assign w_left_gt    = w_gt[g-1];
            assign w_left_value = w_value[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_right_value = '0;
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
        end

        mpq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_item        (i_in_word.item_value),
            .i_valid       (w_valid[g]),
            .i_left_gt     (w_left_gt),
            .i_left_value  (w_left_value),
            .i_right_value (w_right_value),
            .o_gt          (w_gt[g]),
            .o_value       (w_value[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count above depth");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_value[0] <= w_value[1]))
        else $error("chain head out of order");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_word.req_type == REQ_INSERT && !w_full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not grow the queue");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.min_value == '0))
        else $error("nonzero value with error status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
